// File: rtl/dregs_pkg.sv
// Shared definitions for the display register file: command codes, register
// addresses, byte store mapping and the request/result structs.
// No dependencies.
`timescale 1ns / 1ps

package dregs_pkg;

  localparam int LINES_PER_FRAME_DEF = 159;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [7:0] ADDR_LINE      = 8'h02;
  localparam logic [7:0] ADDR_LINE_CMP  = 8'h03;
  localparam logic [7:0] ADDR_SPR_BASE  = 8'h04;
  localparam logic [7:0] ADDR_CTRL_LAST = 8'h15;
  localparam logic [7:0] ADDR_SHADE_LO  = 8'h1C;
  localparam logic [7:0] ADDR_PAL_LO    = 8'h20;
  localparam logic [7:0] ADDR_PAL_HI    = 8'h3F;
  localparam logic [7:0] ADDR_VMODE     = 8'h60;
  localparam logic [7:0] ADDR_MODEL_ID  = 8'hA0;
  localparam logic [7:0] ADDR_TCTRL     = 8'hA2;
  localparam logic [7:0] ADDR_LPER_LO   = 8'hA4;
  localparam logic [7:0] ADDR_LPER_HI   = 8'hA5;
  localparam logic [7:0] ADDR_FPER_LO   = 8'hA6;
  localparam logic [7:0] ADDR_FPER_HI   = 8'hA7;
  localparam logic [7:0] ADDR_LCNT_LO   = 8'hA8;
  localparam logic [7:0] ADDR_LCNT_HI   = 8'hA9;
  localparam logic [7:0] ADDR_FCNT_LO   = 8'hAA;
  localparam logic [7:0] ADDR_FCNT_HI   = 8'hAB;

  localparam logic [7:0] LINE_CMP_RESET = 8'hBB;
  localparam logic [7:0] VBLANK_LINE    = 8'd144;
  localparam logic [7:0] MODEL_ID_COLOR = 8'h87;
  localparam logic [7:0] MODEL_ID_MONO  = 8'h86;
  localparam logic [7:0] SPR_BASE_MASK  = 8'h3F;
  localparam logic [7:0] PAL_MASK       = 8'h77;

  // control bytes 0x00..0x15, then shades and palettes 0x1C..0x3F
  localparam int STORE_DEPTH = 58;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam logic [7:0] STORE_GAP = ADDR_SHADE_LO - ADDR_CTRL_LAST - 8'd1;

  typedef struct packed {
    logic       en;
    logic       wr;
    logic [7:0] addr;
    logic [7:0] wdata;
  } store_req_t;

  typedef struct packed {
    logic       use_store;
    logic [7:0] rd;
    logic [7:0] line;
    logic       vb;
    logic       lt;
    logic       hit;
    logic       ft;
  } result_t;

  function automatic logic in_store(input logic [7:0] a);
    in_store = (a <= ADDR_CTRL_LAST) || ((a >= ADDR_SHADE_LO) && (a <= ADDR_PAL_HI));
  endfunction

  function automatic logic [STORE_AW-1:0] store_index(input logic [7:0] a);
    logic [7:0] idx;
    idx = (a <= ADDR_CTRL_LAST) ? a : (a - STORE_GAP);
    store_index = idx[STORE_AW-1:0];
  endfunction

endpackage

// File: rtl/dregs_bytes.sv
// Byte store for control bytes, shade pairs and mono palettes.
// Synchronous RAM with per-entry valid bits; depends on dregs_pkg.
`timescale 1ns / 1ps

module dregs_bytes (
  input  logic                 clk,
  input  logic                 rst,
  input  dregs_pkg::store_req_t req,
  output logic [7:0]           rd_data
);

  logic [7:0] mem [dregs_pkg::STORE_DEPTH];
  logic [dregs_pkg::STORE_DEPTH-1:0] valid;
  logic [7:0] mem_q;
  logic       valid_q;
  logic [dregs_pkg::STORE_AW-1:0] idx;
  logic [7:0] wdata;
  logic       do_wr;

  always_comb begin
    idx   = dregs_pkg::store_index(req.addr);
    do_wr = req.en && req.wr && dregs_pkg::in_store(req.addr) &&
            (req.addr != dregs_pkg::ADDR_LINE);
    wdata = req.wdata;
    if (req.addr == dregs_pkg::ADDR_SPR_BASE) begin
      wdata = req.wdata & dregs_pkg::SPR_BASE_MASK;
    end else if (req.addr >= dregs_pkg::ADDR_PAL_LO) begin
      wdata = req.wdata & dregs_pkg::PAL_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[idx] <= wdata;
    end
    if (req.en && !req.wr) begin
      mem_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (do_wr) begin
        valid[idx] <= 1'b1;
      end
      if (req.en && !req.wr) begin
        valid_q <= valid[idx];
      end
    end
  end

  // never-written entries read as their reset value, zero
  assign rd_data = valid_q ? mem_q : 8'h00;

endmodule

// File: rtl/display_registers_line_timers_top.sv
// Display register file top: timers, scanline counter, result pipeline.
// Depends on dregs_pkg and dregs_bytes.
`timescale 1ns / 1ps

// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// in       | in_valid / in_stall    | cmd, address, write_data
// out      | out_valid / out_stall  | read_data, line_number, four irq flags
// cfg      | cfg_valid / cfg_ready  | color_model
//
// One request per cycle sustained while out_stall is low; each result is
// registered in the result stage s1 (byte store read), then in the output
// register, from which it is taken when out_stall is low.
// Timer, line and period state update at the accept edge; only the byte
// store read is resolved in the result stage.
// rst is synchronous; store entries come up as zero through valid bits, so
// there is no clearing pass. in_stall rises only when both the result stage
// and the output register are full and out_stall is high.

module display_registers_line_timers_top #(
  parameter int LINES_PER_FRAME = dregs_pkg::LINES_PER_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] address,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic [7:0] line_number,
  output logic       vblank_irq,
  output logic       line_timer_irq,
  output logic       line_hit_irq,
  output logic       frame_timer_irq,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       color_model
);

  localparam logic [7:0] LAST_LINE = 8'(LINES_PER_FRAME - 1);

  // architectural registers
  logic        color;
  logic [7:0]  line_cmp, line_cmp_next;
  logic [7:0]  vmode, vmode_next;
  logic [7:0]  tctrl, tctrl_next;
  logic [15:0] lper, lper_next;
  logic [15:0] fper, fper_next;
  logic [15:0] lcnt, lcnt_next;
  logic [15:0] fcnt, fcnt_next;
  logic [7:0]  cur, cur_next;

  dregs_pkg::result_t res;
  dregs_pkg::result_t s1;
  dregs_pkg::result_t s1_out;
  logic               s1_valid;
  dregs_pkg::result_t out_res;
  logic [7:0]         store_rd;
  dregs_pkg::store_req_t sreq;

  logic acc;
  logic s1_move;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign acc      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign sreq.en    = acc && ((cmd == dregs_pkg::CMD_WRITE) || (cmd == dregs_pkg::CMD_READ));
  assign sreq.wr    = (cmd == dregs_pkg::CMD_WRITE);
  assign sreq.addr  = address;
  assign sreq.wdata = write_data;

  dregs_bytes u_bytes (
    .clk     (clk),
    .rst     (rst),
    .req     (sreq),
    .rd_data (store_rd)
  );

  always_comb begin
    line_cmp_next = line_cmp;
    vmode_next    = vmode;
    tctrl_next    = tctrl;
    lper_next     = lper;
    fper_next     = fper;
    lcnt_next     = lcnt;
    fcnt_next     = fcnt;
    cur_next      = cur;
    res           = '0;

    case (cmd)
      dregs_pkg::CMD_WRITE: begin
        case (address)
          dregs_pkg::ADDR_LINE_CMP: line_cmp_next = write_data;
          dregs_pkg::ADDR_VMODE:    vmode_next    = write_data;
          dregs_pkg::ADDR_TCTRL: begin
            // enabling a timer from off loads its counter
            if (write_data[0] && !tctrl[0]) lcnt_next = lper;
            if (write_data[2] && !tctrl[2]) fcnt_next = fper;
            tctrl_next = write_data;
          end
          dregs_pkg::ADDR_LPER_LO: lper_next = {lper[15:8], write_data};
          dregs_pkg::ADDR_LPER_HI: begin
            lper_next = {write_data, lper[7:0]};
            lcnt_next = {write_data, lper[7:0]};
          end
          dregs_pkg::ADDR_FPER_LO: fper_next = {fper[15:8], write_data};
          dregs_pkg::ADDR_FPER_HI: begin
            fper_next = {write_data, fper[7:0]};
            fcnt_next = {write_data, fper[7:0]};
          end
          default: ;
        endcase
      end
      dregs_pkg::CMD_READ: begin
        if (dregs_pkg::in_store(address) && (address != dregs_pkg::ADDR_LINE) &&
            (address != dregs_pkg::ADDR_LINE_CMP)) begin
          res.use_store = 1'b1;
        end else begin
          case (address)
            dregs_pkg::ADDR_LINE:     res.rd = cur;
            dregs_pkg::ADDR_LINE_CMP: res.rd = line_cmp;
            dregs_pkg::ADDR_VMODE:    res.rd = vmode;
            dregs_pkg::ADDR_MODEL_ID:
              res.rd = color ? dregs_pkg::MODEL_ID_COLOR : dregs_pkg::MODEL_ID_MONO;
            dregs_pkg::ADDR_TCTRL:    res.rd = tctrl;
            dregs_pkg::ADDR_LPER_LO:  res.rd = lper[7:0];
            dregs_pkg::ADDR_LPER_HI:  res.rd = lper[15:8];
            dregs_pkg::ADDR_FPER_LO:  res.rd = fper[7:0];
            dregs_pkg::ADDR_FPER_HI:  res.rd = fper[15:8];
            dregs_pkg::ADDR_LCNT_LO:  res.rd = lcnt[7:0];
            dregs_pkg::ADDR_LCNT_HI:  res.rd = lcnt[15:8];
            dregs_pkg::ADDR_FCNT_LO:  res.rd = fcnt[7:0];
            dregs_pkg::ADDR_FCNT_HI:  res.rd = fcnt[15:8];
            default:                  res.rd = 8'h00;
          endcase
        end
      end
      dregs_pkg::CMD_TICK: begin
        res.vb = (cur == dregs_pkg::VBLANK_LINE);
        // line timer: counts on every tick while enabled and nonzero
        if ((lcnt != 16'd0) && tctrl[0]) begin
          lcnt_next = lcnt - 16'd1;
          if (lcnt == 16'd1) begin
            res.lt = 1'b1;
            if (tctrl[1]) lcnt_next = lper;
          end
        end
        cur_next = (cur == LAST_LINE) ? 8'd0 : (cur + 8'd1);
        res.hit  = (cur_next == line_cmp);
        // frame timer: steps only when the line wraps
        if ((cur_next == 8'd0) && (fcnt != 16'd0) && tctrl[2]) begin
          fcnt_next = fcnt - 16'd1;
          if (fcnt == 16'd1) begin
            res.ft = 1'b1;
            if (tctrl[3]) fcnt_next = fper;
          end
        end
      end
      default: ;
    endcase

    res.line = cur_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      color    <= 1'b0;
      line_cmp <= dregs_pkg::LINE_CMP_RESET;
      vmode    <= '0;
      tctrl    <= '0;
      lper     <= '0;
      fper     <= '0;
      lcnt     <= '0;
      fcnt     <= '0;
      cur      <= '0;
    end else begin
      if (cfg_valid) begin
        color <= color_model;
      end
      if (acc) begin
        line_cmp <= line_cmp_next;
        vmode    <= vmode_next;
        tctrl    <= tctrl_next;
        lper     <= lper_next;
        fper     <= fper_next;
        lcnt     <= lcnt_next;
        fcnt     <= fcnt_next;
        cur      <= cur_next;
      end
    end
  end

  // result stage and output register: control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // store read data joins the result as it leaves s1
  always_comb begin
    s1_out = s1;
    if (s1.use_store) begin
      s1_out.rd = store_rd;
    end
  end

  // payload; store read data holds while s1 waits (no new read without accept)
  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= res;
    end
    if (s1_move) begin
      out_res <= s1_out;
    end
  end

  assign read_data       = out_res.rd;
  assign line_number     = out_res.line;
  assign vblank_irq      = out_res.vb;
  assign line_timer_irq  = out_res.lt;
  assign line_hit_irq    = out_res.hit;
  assign frame_timer_irq = out_res.ft;

endmodule
